// ----- src/u8d_pkg.sv -----
// Shared types, status codes and lead-byte tables for the UTF-8 stream decoder.
// No dependencies; every other source file imports this package.
package u8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 31;
  localparam int unsigned LenW  = 3;
  localparam int unsigned StW   = 3;
  localparam int unsigned ContW = 6;

  typedef enum logic [StW-1:0] {
    STATUS_OK       = 3'd0,
    STATUS_BAD_LEAD = 3'd1,
    STATUS_NO_CONT  = 3'd2,
    STATUS_TRUNC    = 3'd3,
    STATUS_OVERLONG = 3'd4
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [CpW-1:0]  char_value;
    logic [LenW-1:0] seq_length;
    status_e         status;
  } out_item_t;

  // Result of one decode step toward the output register.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } step_res_t;

  // Sequence length from a lead byte; zero marks a byte that cannot lead.
  function automatic logic [LenW-1:0] lead_length(input logic [ByteW-1:0] b);
    logic [LenW-1:0] len;
    case (b) inside
      [8'h00:8'h7F]: len = 3'd1;
      [8'hC0:8'hDF]: len = 3'd2;
      [8'hE0:8'hEF]: len = 3'd3;
      [8'hF0:8'hF7]: len = 3'd4;
      [8'hF8:8'hFB]: len = 3'd5;
      [8'hFC:8'hFD]: len = 3'd6;
      default:       len = 3'd0;
    endcase
    return len;
  endfunction

  // Payload bits carried by the lead byte of a sequence of the given length.
  function automatic logic [ByteW-1:0] lead_mask(input logic [LenW-1:0] len);
    logic [ByteW-1:0] m;
    case (len)
      3'd1:    m = 8'h7F;
      3'd2:    m = 8'h1F;
      3'd3:    m = 8'h0F;
      3'd4:    m = 8'h07;
      3'd5:    m = 8'h03;
      3'd6:    m = 8'h01;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  // Smallest value that a sequence of the given length may encode.
  function automatic logic [CpW-1:0] min_value(input logic [LenW-1:0] len);
    logic [CpW-1:0] v;
    case (len)
      3'd2:    v = 31'h0000_0080;
      3'd3:    v = 31'h0000_0800;
      3'd4:    v = 31'h0001_0000;
      3'd5:    v = 31'h0020_0000;
      3'd6:    v = 31'h0400_0000;
      default: v = 31'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

// ----- src/u8d_in_reg.sv -----
// Input register stage: captures one byte item and holds it until the
// decode step consumes it. Depends on u8d_pkg.
module u8d_in_reg import u8d_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_item_i,
  output logic     in_stall_o,
  input  logic     advance_i,
  output logic     valid_o,
  output in_item_t item_o
);

  logic     valid_q;
  in_item_t item_q;

  // Stall only while a held item cannot move on this cycle.
  assign in_stall_o = valid_q && !advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- src/u8d_step.sv -----
// Per-byte decode step: sequence state registers and the combinational
// next-state and result logic. Depends on u8d_pkg.
module u8d_step import u8d_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      advance_i,
  input  in_item_t  item_i,
  output step_res_t res_o
);

  logic [LenW-1:0] br_q, br_d;
  logic [LenW-1:0] sz_q, sz_d;
  logic [CpW-1:0]  acc_q, acc_d;

  logic [ByteW-1:0] b;
  logic             last;
  logic [LenW-1:0]  len;
  logic [LenW-1:0]  br_m1;
  logic [LenW-1:0]  size;
  logic [CpW-1:0]   acc_sh;
  logic [ByteW-1:0] lead_bits;

  assign b         = item_i.data_byte;
  assign last      = item_i.end_of_buffer;
  assign len       = lead_length(b);
  assign lead_bits = b & lead_mask(len);
  assign br_m1     = br_q - 3'd1;
  assign size      = (sz_q > 3'd6) ? 3'd6 : sz_q;
  assign acc_sh    = {acc_q[CpW-ContW-1:0], b[ContW-1:0]};

  always_comb begin
    br_d  = br_q;
    sz_d  = sz_q;
    acc_d = acc_q;
    res_o = '0;
    res_o.item.status = STATUS_OK;

    if (br_q == 3'd0) begin
      if (len == 3'd0) begin
        res_o.valid       = 1'b1;
        res_o.item.status = STATUS_BAD_LEAD;
      end else if (len == 3'd1) begin
        res_o.valid           = 1'b1;
        res_o.item.char_value = {24'd0, b[6:0]};
        res_o.item.seq_length = 3'd1;
      end else if (last) begin
        res_o.valid       = 1'b1;
        res_o.item.status = STATUS_TRUNC;
      end else begin
        sz_d  = len;
        br_d  = len - 3'd1;
        acc_d = {23'd0, lead_bits};
      end
    end else if (last && (br_q > 3'd1)) begin
      res_o.valid       = 1'b1;
      res_o.item.status = STATUS_TRUNC;
    end else if (b[7:6] != 2'b10) begin
      res_o.valid       = 1'b1;
      res_o.item.status = STATUS_NO_CONT;
    end else if (br_m1 != 3'd0) begin
      br_d  = br_m1;
      acc_d = acc_sh;
    end else if (acc_sh < min_value(size)) begin
      res_o.valid       = 1'b1;
      res_o.item.status = STATUS_OVERLONG;
    end else begin
      res_o.valid           = 1'b1;
      res_o.item.char_value = acc_sh;
      res_o.item.seq_length = size;
    end

    // Any result ends the sequence: drop back to idle.
    if (res_o.valid) begin
      br_d  = 3'd0;
      sz_d  = 3'd0;
      acc_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      br_q  <= 3'd0;
      sz_q  <= 3'd0;
      acc_q <= '0;
    end else if (advance_i) begin
      br_q  <= br_d;
      sz_q  <= sz_d;
      acc_q <= acc_d;
    end
  end

  a_busy_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (br_q != 3'd0) |-> (sz_q >= 3'd2 && sz_q <= 3'd6 && br_q < sz_q))
    else $error("busy with an impossible sequence size");

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (br_q == 3'd0) |-> (sz_q == 3'd0))
    else $error("sequence size left over while idle");

  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(advance_i) && $past(br_q) != 3'd0 && br_q != 3'd0)
      |-> (br_q == $past(br_q) - 3'd1))
    else $error("remaining count did not step down by one");

endmodule

// ----- src/u8d_out_reg.sv -----
// Output register: holds one result item until the consumer takes it.
// Depends on u8d_pkg.
module u8d_out_reg import u8d_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  out_item_t item_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      valid_q;
  out_item_t item_q;

  // Free when empty or when the held item leaves this cycle.
  assign free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      item_q <= item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

// ----- src/utf8_stream_decoder_core.sv -----
// Top level of the streaming UTF-8 decoder (original form, up to six bytes).
// Depends on u8d_pkg, u8d_in_reg, u8d_step and u8d_out_reg.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------------
//   in      | input     | in_valid_i/in_stall_o | in_item_i: data_byte, end_of_buffer
//   out     | output    | out_valid_o/out_stall_i | out_item_o: char_value,
//           |           |                       |   seq_length, status
//
// One byte item is taken every cycle unless the input stalls; the byte that
// completes or breaks a sequence yields a result via the input register, then
// the result register. The decode step between them is a single shallow pass.
// Reset clears both valid flags and returns the sequence state to idle.
// A stalled output holds its item; the input stalls only when the held byte
// must wait for the output register to free up.
module utf8_stream_decoder_core import u8d_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  in_item_t  in_item_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output out_item_t out_item_o,
  input  logic      out_stall_i
);

  logic      stage_valid;
  in_item_t  stage_item;
  logic      out_free;
  logic      advance;
  step_res_t res;

  // Advance the held byte only when its possible result has a place to go.
  assign advance = stage_valid && out_free;

  u8d_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  // Decode state lives here and moves only on advance.
  u8d_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (stage_item),
    .res_o     (res)
  );

  // Load a result only for bytes that end a sequence or raise an error.
  u8d_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && res.valid),
    .item_i      (res.item),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status != STATUS_OK)
      |-> (out_item_o.char_value == '0 && out_item_o.seq_length == 3'd0))
    else $error("error result carries a value or length");

  a_ok_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status == STATUS_OK)
      |-> (out_item_o.seq_length >= 3'd1 && out_item_o.seq_length <= 3'd6))
    else $error("ok result with impossible length");

  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (stage_valid && out_valid_o && out_stall_i))
    else $error("input stalled without a blocked output");

endmodule
